@@ sv/adcema_pkg.sv @@
// Shared constants and types for the converter EMA / moving-average filter.
package adcema_pkg;

	localparam int WINDOW_DEF = 30;
	localparam int SAMPLE_W   = 14;
	localparam int WEIGHT_W   = 17;
	localparam int Q_W        = 22;
	localparam int FRAC_W     = 8;
	localparam int SAMPLE_MAX = 16383;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd32768;

	// one sample moving into the averaging state
	typedef struct packed {
		logic                en;
		logic [SAMPLE_W-1:0] sample;
	} step_t;

endpackage

@@ sv/adcema_ema.sv @@
// Exponential average state: level += weight * (sample - level), truncated.
module adcema_ema (
	input  logic                          clk,
	input  logic                          arst_n,
	input  adcema_pkg::step_t             step,
	input  logic [adcema_pkg::WEIGHT_W-1:0] weight,
	output logic [adcema_pkg::Q_W-1:0]    level
);
	import adcema_pkg::*;

	localparam int DIFF_W = Q_W + 1;
	localparam int PROD_W = DIFF_W + WEIGHT_W + 1;

	logic [Q_W-1:0]           level_q;
	logic signed [DIFF_W-1:0] diff;
	logic signed [WEIGHT_W:0] w_s;
	logic signed [PROD_W-1:0] prod;
	logic signed [Q_W+1:0]    lvl_ext;
	logic signed [Q_W+1:0]    lvl_next;

	always_comb begin
		diff     = $signed({1'b0, step.sample, {FRAC_W{1'b0}}}) - $signed({1'b0, level_q});
		w_s      = $signed({1'b0, weight});
		prod     = diff * w_s;
		lvl_ext  = $signed({2'b00, level_q});
		// floor(prod / 2^16) fits in Q_W+2 bits
		lvl_next = lvl_ext + prod[16 +: Q_W + 2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (step.en) begin
			level_q <= lvl_next[Q_W-1:0];
		end
	end

	assign level = level_q;

endmodule

@@ sv/adcema_ring.sv @@
// Sample ring with running window sum; read of the retiring slot is prefetched.
module adcema_ring #(
	parameter int WINDOW = adcema_pkg::WINDOW_DEF,
	parameter int SUM_W  = $clog2(WINDOW * adcema_pkg::SAMPLE_MAX + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  adcema_pkg::step_t step,
	output logic [SUM_W-1:0]  sum
);
	import adcema_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

	logic [SAMPLE_W-1:0] mem_q [WINDOW];
	logic [WINDOW-1:0]   fill_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   slot_next;
	logic [SAMPLE_W-1:0] rd_data_q;
	logic                rd_vld_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] old_sample;

	always_comb begin
		if (step.en) begin
			slot_next = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
		end else begin
			slot_next = slot_q;
		end
		// never-written slots read as zero
		old_sample = rd_vld_q ? rd_data_q : '0;
	end

	// storage; next slot differs from the one written whenever a write happens
	always_ff @(posedge clk) begin
		if (step.en) begin
			mem_q[slot_q] <= step.sample;
		end
		rd_data_q <= mem_q[slot_next];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_vld_q <= 1'b0;
			slot_q   <= '0;
			sum_q    <= '0;
		end else begin
			rd_vld_q <= fill_q[slot_next];
			if (step.en) begin
				fill_q[slot_q] <= 1'b1;
				slot_q         <= slot_next;
				sum_q          <= sum_q - SUM_W'(old_sample) + SUM_W'(step.sample);
			end
		end
	end

	assign sum = sum_q;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_LAST)
		else $error("ring slot out of range");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(WINDOW * SAMPLE_MAX))
		else $error("window sum exceeds full-scale bound");

	a_fill_set: assert property (@(posedge clk) disable iff (!arst_n)
		step.en |=> fill_q[$past(slot_q)])
		else $error("written slot not marked filled");

endmodule

@@ sv/adcema_div.sv @@
// Window mean: (sum << 8) / WINDOW by exact reciprocal multiply.
module adcema_div #(
	parameter int WINDOW = adcema_pkg::WINDOW_DEF,
	parameter int SUM_W  = $clog2(WINDOW * adcema_pkg::SAMPLE_MAX + 1)
) (
	input  logic [SUM_W-1:0]           sum,
	output logic [adcema_pkg::Q_W-1:0] mean
);
	import adcema_pkg::*;

	localparam int X_W   = SUM_W + FRAC_W;
	localparam int SHIFT = X_W + $clog2(WINDOW);
	localparam int M_W   = X_W + 1;
	localparam int P_W   = X_W + M_W;
	// ceil(2^SHIFT / WINDOW): exact floor quotient for any X_W-bit dividend
	localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

	logic [X_W-1:0] dividend;
	logic [P_W-1:0] prod;
	logic [P_W-1:0] quot;

	always_comb begin
		dividend = {sum, {FRAC_W{1'b0}}};
		prod     = P_W'(dividend) * P_W'(RECIP[M_W-1:0]);
		quot     = prod >> SHIFT;
		mean     = quot[Q_W-1:0];
	end

endmodule

@@ sv/adc_ema_and_moving_average_top.sv @@
// Throughput: one transaction per cycle when neither side stalls; either side may stall freely.
// Stages: input register, averaging state update (EMA and ring sum), output register.
// Reset clears all valid flags, both averages, the ring fill flags and slot; weight = 1/2.
// Ring entries not yet written read as zero, so no clearing pass is needed after reset.
// Config writes are always ready and must only be issued while the pipe is empty.
module adc_ema_and_moving_average_top #(
	parameter int WINDOW = adcema_pkg::WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [adcema_pkg::WEIGHT_W-1:0] ema_weight,
	// sample in
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [adcema_pkg::SAMPLE_W-1:0] sample,
	// result out
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [adcema_pkg::SAMPLE_W-1:0] raw_echo,
	output logic [adcema_pkg::Q_W-1:0]      ema_out,
	output logic [adcema_pkg::Q_W-1:0]      mean_out
);
	import adcema_pkg::*;

	localparam int SUM_W = $clog2(WINDOW * SAMPLE_MAX + 1);

	logic [WEIGHT_W-1:0] weight_q;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                valid_s2;
	logic [SAMPLE_W-1:0] raw_s2;
	logic                valid_s3;
	logic [SAMPLE_W-1:0] raw_s3;
	logic [Q_W-1:0]      ema_s3;
	logic [Q_W-1:0]      mean_s3;

	logic                adv1;
	logic                adv2;
	logic                in_take;
	step_t               step;
	logic [Q_W-1:0]      ema_level;
	logic [SUM_W-1:0]    win_sum;
	logic [Q_W-1:0]      win_mean;

	// pipeline flow: a stage moves when the one after it is empty or moving
	always_comb begin
		adv2        = valid_s2 && (!valid_s3 || !out_stall);
		adv1        = valid_s1 && (!valid_s2 || adv2);
		in_stall    = valid_s1 && !adv1;
		in_take     = in_valid && !in_stall;
		step.en     = adv1;
		step.sample = sample_s1;
	end

	assign cfg_ready = 1'b1;

	// weight stored already clamped to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			weight_q <= (ema_weight > WEIGHT_ONE) ? WEIGHT_ONE : ema_weight;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv2) begin
				valid_s3 <= 1'b1;
			end else if (!out_stall) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= sample;
		end
		if (adv1) begin
			raw_s2 <= sample_s1;
		end
		if (adv2) begin
			raw_s3  <= raw_s2;
			ema_s3  <= ema_level;
			mean_s3 <= win_mean;
		end
	end

	// EMA and ring state hold the s2 values while s2 is occupied
	adcema_ema u_ema (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.weight (weight_q),
		.level  (ema_level)
	);

	adcema_ring #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sum    (win_sum)
	);

	adcema_div #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_div (
		.sum  (win_sum),
		.mean (win_mean)
	);

	assign out_valid = valid_s3;
	assign raw_echo  = raw_s3;
	assign ema_out   = ema_s3;
	assign mean_out  = mean_s3;

	a_weight_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		weight_q <= WEIGHT_ONE)
		else $error("stored weight above one");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty first stage");

	a_s2_filled: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 |=> valid_s2 && raw_s2 == $past(sample_s1))
		else $error("state-update stage lost a transaction");

endmodule

@@ tb/adcema_filter_checker.sv @@
// Checker for the converter EMA / moving-average filter: predicts each result and compares.
module adcema_filter_checker #(
	parameter int WINDOW = adcema_pkg::WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [adcema_pkg::WEIGHT_W-1:0] ema_weight,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [adcema_pkg::SAMPLE_W-1:0] sample,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [adcema_pkg::SAMPLE_W-1:0] raw_echo,
	input  logic [adcema_pkg::Q_W-1:0]      ema_out,
	input  logic [adcema_pkg::Q_W-1:0]      mean_out,
	output int                              mismatches,
	output int                              pending
);
	import adcema_pkg::*;

	typedef struct packed {
		logic [SAMPLE_W-1:0] raw;
		logic [Q_W-1:0]      ema;
		logic [Q_W-1:0]      mean;
	} filter_result_t;

	filter_result_t      expected_results[$];
	logic [WEIGHT_W-1:0] weight;
	logic [Q_W-1:0]      level;
	logic [SAMPLE_W-1:0] ring[WINDOW];
	int                  slot;
	logic [31:0]         ring_sum;
	int                  bad_count;

	function automatic void note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (bad_count < 10)
			$display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
		bad_count++;
	endfunction

	// advance both averages by one sample and queue the result
	function automatic void advance_filters(input logic [SAMPLE_W-1:0] s);
		logic [63:0]    w;
		logic [63:0]    acc;
		logic [63:0]    wide_sum;
		filter_result_t r;
		w   = (weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(weight);
		acc = w * (64'(s) << 8) + (64'(WEIGHT_ONE) - w) * 64'(level);
		level = acc[37:16];

		if (slot >= WINDOW)
			slot = 0;
		ring_sum   = ring_sum - ring[slot] + s;
		ring[slot] = s;
		slot       = (slot + 1 >= WINDOW) ? 0 : slot + 1;
		wide_sum   = (64'(ring_sum) << 8) / WINDOW;

		r.raw  = s;
		r.ema  = level;
		r.mean = wide_sum[Q_W-1:0];
		expected_results.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filter_result_t want;
		if (!arst_n) begin
			weight   = WEIGHT_RESET;
			level    = '0;
			slot     = 0;
			ring_sum = '0;
			for (int i = 0; i < WINDOW; i++)
				ring[i] = '0;
			expected_results.delete();
			bad_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				weight = ema_weight;
			if (in_valid && !in_stall)
				advance_filters(sample);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					note_mismatch("unexpected result, raw_echo", '0, 32'(raw_echo));
				end else begin
					want = expected_results.pop_front();
					if (raw_echo !== want.raw)
						note_mismatch("raw_echo", 32'(want.raw), 32'(raw_echo));
					if (ema_out !== want.ema)
						note_mismatch("ema_out", 32'(want.ema), 32'(ema_out));
					if (mean_out !== want.mean)
						note_mismatch("mean_out", 32'(want.mean), 32'(mean_out));
				end
			end
		end
		pending    <= expected_results.size();
		mismatches <= bad_count;
	end

endmodule

@@ tb/tb_adc_ema_and_moving_average_top.sv @@
// Testbench top for the converter EMA / moving-average filter: stimulus, watchdog and verdict.
module tb_adc_ema_and_moving_average_top;
	import adcema_pkg::*;

	// no transaction for this many cycles means the block has hung
	localparam int IDLE_LIMIT = 1000;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [WEIGHT_W-1:0] ema_weight;
	logic                in_valid;
	logic                in_stall;
	logic [SAMPLE_W-1:0] sample;
	logic                out_valid;
	logic                out_stall;
	logic [SAMPLE_W-1:0] raw_echo;
	logic [Q_W-1:0]      ema_out;
	logic [Q_W-1:0]      mean_out;

	int   mismatches;
	int   pending;
	int   idle_cycles;
	// when set, neither side inserts gaps or stalls
	logic no_idle;

	adc_ema_and_moving_average_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.ema_weight (ema_weight),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.raw_echo   (raw_echo),
		.ema_out    (ema_out),
		.mean_out   (mean_out)
	);

	adcema_filter_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.ema_weight (ema_weight),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.raw_echo   (raw_echo),
		.ema_out    (ema_out),
		.mean_out   (mean_out),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One sample transaction. The gap is drawn per item; with a zero gap valid stays
	// high, so it is never dropped and raised in the same step.
	task automatic send_sample(input logic [SAMPLE_W-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= v;
		// stall read right after the edge is still its pre-edge value
		do @(posedge clk); while (in_stall);
	endtask

	// Hold off the sender until every queued result has come out. The extra edge lets the
	// checker count a transaction accepted at the edge we were called on.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// The weight register may only change with the pipe empty.
	task automatic write_weight(input logic [WEIGHT_W-1:0] w);
		drain_pipe();
		cfg_valid  <= 1'b1;
		ema_weight <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random content in a few shapes. Long constant runs (at least as long as the window)
	// let the mean settle and the EMA converge; the rest is noise and rail-to-rail hits.
	function automatic logic [SAMPLE_W-1:0] draw_sample(input int shape,
			input logic [SAMPLE_W-1:0] held);
		int pick;
		pick = $urandom_range(0, 9);
		case (shape)
			0: draw_sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
			1: begin
				if (pick < 4)
					draw_sample = (pick[0]) ? SAMPLE_W'(SAMPLE_MAX) : '0;
				else if (pick < 7)
					draw_sample = SAMPLE_W'(SAMPLE_MAX - $urandom_range(0, 3));
				else
					draw_sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
			end
			default: draw_sample = (pick == 0) ? SAMPLE_W'($urandom_range(0, SAMPLE_MAX)) : held;
		endcase
	endfunction

	// Stimulus: directed corners first, then random phases with varied weights.
	initial begin
		logic [WEIGHT_W-1:0] phase_weight[10];
		logic [SAMPLE_W-1:0] held;
		int                  run_left;
		int                  shape;
		int                  n_items;

		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		ema_weight = '0;
		in_valid   = 1'b0;
		sample     = '0;
		no_idle    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset weight of one half. Start-up ramp: ring and average begin at zero.
		send_sample(SAMPLE_W'(0));
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(SAMPLE_W'(0));
		send_sample(SAMPLE_W'('h2AAA));
		send_sample(SAMPLE_W'('h1555));
		send_sample(SAMPLE_W'(1));
		send_sample(SAMPLE_W'(SAMPLE_MAX - 1));
		send_sample(SAMPLE_W'(8192));

		// Weight of exactly one: the EMA tracks the sample.
		write_weight(WEIGHT_ONE);
		send_sample(SAMPLE_W'('h1555));
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(SAMPLE_W'(0));

		// Weight zero: the EMA holds.
		write_weight('0);
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(SAMPLE_W'('h2AAA));
		send_sample(SAMPLE_W'(0));

		// Weight field all ones, above one: clamps to one.
		write_weight({WEIGHT_W{1'b1}});
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(SAMPLE_W'(12345));

		// Just above one, and the smallest nonzero weight.
		write_weight(WEIGHT_ONE + 1'b1);
		send_sample(SAMPLE_W'(777));
		write_weight(WEIGHT_W'(1));
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(SAMPLE_W'(SAMPLE_MAX));

		// Random phases, about 450 samples in all.
		phase_weight[0] = WEIGHT_W'(32768);
		phase_weight[1] = WEIGHT_ONE;
		phase_weight[2] = WEIGHT_W'(1);
		phase_weight[3] = WEIGHT_W'(65535);
		phase_weight[4] = '0;
		phase_weight[5] = {WEIGHT_W{1'b1}};
		phase_weight[6] = WEIGHT_W'(4096);
		phase_weight[7] = WEIGHT_W'($urandom_range(0, 65536));
		phase_weight[8] = WEIGHT_W'($urandom_range(0, 131071));
		phase_weight[9] = WEIGHT_W'(16);

		held     = '0;
		run_left = 0;
		for (int p = 0; p < 10; p++) begin
			write_weight(phase_weight[p]);
			// every third phase runs back to back on both sides
			no_idle = (p % 3 == 2);
			shape   = (p % 4 == 3) ? 1 : ((p % 2 == 0) ? 2 : 0);
			n_items = 45;
			for (int i = 0; i < n_items; i++) begin
				if (run_left == 0) begin
					held     = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
					run_left = $urandom_range(30, 45);
				end
				run_left--;
				// sender sits out until the pipe is empty, then resumes mid-phase
				if (p % 2 == 1 && i == n_items / 2)
					drain_pipe();
				send_sample(draw_sample(shape, held));
			end
		end

		drain_pipe();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Result side: a fresh stall length for each result, zero in the back-to-back phases.
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 8);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Watchdog: counts cycles with no transaction on any channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule

@@ adc_ema_and_moving_average_top.f @@
sv/adcema_pkg.sv
sv/adcema_ema.sv
sv/adcema_ring.sv
sv/adcema_div.sv
sv/adc_ema_and_moving_average_top.sv
tb/adcema_filter_checker.sv
tb/tb_adc_ema_and_moving_average_top.sv
